@@ hw/rtl/assert_macros.svh @@
// assertion helpers, clocked on clk and held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true at a rising edge out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ hw/rtl/frdf_pkg.sv @@
package frdf_pkg;

    // configuration register indexes
    localparam logic CFG_RELAY_TYPE = 1'b0;
    localparam logic CFG_TIMEOUT    = 1'b1;

    localparam logic [15:0] TIMEOUT_RESET = 16'd30;
    localparam logic [7:0]  MIN_LEN       = 8'd9;

    // verdict codes
    localparam logic [2:0] VERDICT_FORWARD    = 3'd0;
    localparam logic [2:0] VERDICT_WRONG_TYPE = 3'd1;
    localparam logic [2:0] VERDICT_TOO_SHORT  = 3'd2;
    localparam logic [2:0] VERDICT_DUPLICATE  = 3'd3;
    localparam logic [2:0] VERDICT_TTL_ZERO   = 3'd4;
    localparam logic [2:0] VERDICT_SWEEP_DONE = 3'd5;

    localparam int ORIGIN_W = 16;
    localparam int EVENT_W  = 32;
    localparam int STAMP_W  = 32;
    localparam int ENTRY_W  = ORIGIN_W + EVENT_W + STAMP_W;

    typedef struct packed {
        logic start;   // capture item, clear scan accumulators
        logic issue;   // read the next table entry
        logic finish;  // write back and load the result
    } frdf_cmd_t;

    typedef struct packed {
        logic scan_last;  // the last entry is being read
        logic out_free;   // result register can take a new result
    } frdf_status_t;

endpackage

@@ hw/rtl/frdf_ram.sv @@
module frdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/frdf_ctrl.sv @@
`include "assert_macros.svh"

module frdf_ctrl
    import frdf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  frdf_status_t status,
    output frdf_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;
    logic   accept;

    assign accept   = in_valid && !in_stall_reg;
    assign in_stall = in_stall_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd.start  = accept;
        cmd.issue  = (state_reg == ST_SCAN);
        cmd.finish = (state_reg == ST_FINISH) && status.out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    `ASSERT_CLK(a_start_to_scan, cmd.start |=> state_reg == ST_SCAN, "accepted item did not start a scan")
    `ASSERT_CLK(a_drain_to_finish, state_reg == ST_DRAIN |=> state_reg == ST_FINISH, "drain did not lead to finish")
    `ASSERT_NEVER(a_no_accept_busy, accept && (state_reg != ST_IDLE), "item accepted while busy")

endmodule

@@ hw/rtl/frdf_datapath.sv @@
`include "assert_macros.svh"

module frdf_datapath
    import frdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  frdf_cmd_t    cmd,
    output frdf_status_t status,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    input  logic         mode,
    input  logic [7:0]   frame_type,
    input  logic [7:0]   body_len,
    input  logic [15:0]  origin_addr,
    input  logic [31:0]  event_id,
    input  logic [7:0]   ttl_in,
    input  logic [31:0]  now_halfsec,
    output logic         out_valid,
    input  logic         out_stall,
    output logic         forward,
    output logic [2:0]   verdict,
    output logic [7:0]   ttl_out,
    output logic [3:0]   slot_written,
    output logic         evicted,
    output logic [4:0]   aged_out
);

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = ($clog2(TABLE_ENTRIES + 1) < 5) ? 5 : $clog2(TABLE_ENTRIES + 1);
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

    // configuration
    logic [7:0]  relay_type_reg;
    logic [15:0] timeout_reg;

    // captured item
    logic        mode_reg;
    logic [7:0]  frame_type_reg;
    logic [7:0]  body_len_reg;
    logic [15:0] origin_reg;
    logic [31:0] event_reg;
    logic [7:0]  ttl_reg;
    logic [31:0] now_reg;

    // scan
    logic [IW-1:0]            rd_addr_reg;
    logic                     chk_vld_reg;
    logic [IW-1:0]            chk_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic                     dup_reg;
    logic                     have_free_reg;
    logic [IW-1:0]            free_slot_reg;
    logic [IW-1:0]            oldest_slot_reg;
    logic [31:0]              oldest_stamp_reg;
    logic [CW-1:0]            aged_cnt_reg;

    // result register
    logic        out_valid_reg;
    logic        forward_reg;
    logic [2:0]  verdict_reg;
    logic [7:0]  ttl_out_reg;
    logic [3:0]  slot_written_reg;
    logic        evicted_reg;
    logic [4:0]  aged_out_reg;

    logic [ENTRY_W-1:0] ram_rdata;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [15:0]        e_origin;
    logic [31:0]        e_event;
    logic [31:0]        e_stamp;
    logic               e_valid;
    logic [31:0]        e_age;
    logic [16:0]        limit;
    logic               e_expired;
    logic [2:0]         verdict_next;
    logic               fwd;
    logic [IW-1:0]      slot;
    logic [IW+3:0]      slot_wide;
    logic               ram_we;

    assign {e_origin, e_event, e_stamp} = ram_rdata;
    assign e_valid   = valid_reg[chk_idx_reg];
    assign e_age     = now_reg - e_stamp;
    assign limit     = {timeout_reg, 1'b0};
    assign e_expired = e_age > {15'd0, limit};

    assign slot      = have_free_reg ? free_slot_reg : oldest_slot_reg;
    assign slot_wide = {4'd0, slot};
    assign ram_wdata = {origin_reg, event_reg, now_reg};

    // checks in priority order
    always_comb
    begin
        if (mode_reg)
        begin
            verdict_next = VERDICT_SWEEP_DONE;
        end
        else if (frame_type_reg != relay_type_reg)
        begin
            verdict_next = VERDICT_WRONG_TYPE;
        end
        else if (body_len_reg < MIN_LEN)
        begin
            verdict_next = VERDICT_TOO_SHORT;
        end
        else if (dup_reg)
        begin
            verdict_next = VERDICT_DUPLICATE;
        end
        else if (ttl_reg == 8'd0)
        begin
            verdict_next = VERDICT_TTL_ZERO;
        end
        else
        begin
            verdict_next = VERDICT_FORWARD;
        end
    end

    assign fwd    = (verdict_next == VERDICT_FORWARD);
    assign ram_we = cmd.finish && fwd;

    frdf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot),
        .wdata (ram_wdata),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            relay_type_reg <= 8'd0;
            timeout_reg    <= TIMEOUT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RELAY_TYPE: relay_type_reg <= cfg_data[7:0];
                CFG_TIMEOUT:    timeout_reg    <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            mode_reg       <= mode;
            frame_type_reg <= frame_type;
            body_len_reg   <= body_len;
            origin_reg     <= origin_addr;
            event_reg      <= event_id;
            ttl_reg        <= ttl_in;
            now_reg        <= now_halfsec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg <= '0;
            chk_vld_reg <= 1'b0;
            chk_idx_reg <= '0;
        end
        else
        begin
            if (cmd.start)
            begin
                rd_addr_reg <= '0;
            end
            else if (cmd.issue)
            begin
                rd_addr_reg <= rd_addr_reg + 1'b1;
            end
            chk_vld_reg <= cmd.issue;
            chk_idx_reg <= rd_addr_reg;
        end
    end

    // valid bits: cleared by a sweep, set on write-back
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (chk_vld_reg && mode_reg && e_valid && e_expired)
        begin
            valid_reg[chk_idx_reg] <= 1'b0;
        end
        else if (ram_we)
        begin
            valid_reg[slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            dup_reg          <= 1'b0;
            have_free_reg    <= 1'b0;
            free_slot_reg    <= '0;
            oldest_slot_reg  <= '0;
            oldest_stamp_reg <= '1;
            aged_cnt_reg     <= '0;
        end
        else if (chk_vld_reg)
        begin
            if (e_valid && (e_origin == origin_reg) && (e_event == event_reg))
            begin
                dup_reg <= 1'b1;
            end
            if (!e_valid)
            begin
                if (!have_free_reg)
                begin
                    have_free_reg <= 1'b1;
                    free_slot_reg <= chk_idx_reg;
                end
            end
            else if (e_stamp < oldest_stamp_reg)
            begin
                oldest_stamp_reg <= e_stamp;
                oldest_slot_reg  <= chk_idx_reg;
            end
            if (mode_reg && e_valid && e_expired)
            begin
                aged_cnt_reg <= CW'(aged_cnt_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            forward_reg      <= fwd;
            verdict_reg      <= verdict_next;
            ttl_out_reg      <= fwd ? (ttl_reg - 8'd1) : ttl_reg;
            slot_written_reg <= fwd ? slot_wide[3:0] : 4'd0;
            evicted_reg      <= fwd && valid_reg[slot];
            aged_out_reg     <= mode_reg ? aged_cnt_reg[4:0] : 5'd0;
        end
    end

    assign status.scan_last = (rd_addr_reg == LAST_IDX);
    assign status.out_free  = !out_valid_reg || !out_stall;

    assign out_valid    = out_valid_reg;
    assign forward      = forward_reg;
    assign verdict      = verdict_reg;
    assign ttl_out      = ttl_out_reg;
    assign slot_written = slot_written_reg;
    assign evicted      = evicted_reg;
    assign aged_out     = aged_out_reg;

    `ASSERT_CLK(a_fwd_matches_verdict, out_valid_reg |-> (forward_reg == (verdict_reg == VERDICT_FORWARD)), "forward flag disagrees with verdict")
    `ASSERT_NEVER(a_no_load_mid_scan, cmd.finish && chk_vld_reg, "result loaded while scan data pending")

endmodule

@@ hw/rtl/flood_relay_dedup_filter.sv @@
// channel | direction | handshake            | payload
// cfg     | in        | cfg_we               | cfg_index, cfg_data
// in      | in        | in_valid / in_stall  | mode, frame_type, body_len, origin_addr,
//         |           |                      | event_id, ttl_in, now_halfsec
// out     | out       | out_valid / out_stall| forward, verdict, ttl_out, slot_written,
//         |           |                      | evicted, aged_out
//
// an item is taken in idle, then the registered-read entry memory is scanned, one entry
// read per cycle, followed by drain and write-back; the sequencer then returns to idle,
// where the next item is taken
// reset clears the valid bits at once; no clearing pass, items are taken straight away
// a result waits in the output register while out_stall is high; the next item is taken
// meanwhile, but its write-back holds until that register frees
module flood_relay_dedup_filter
    import frdf_pkg::*;
#(
    parameter int TABLE_ENTRIES = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // configuration writes
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [15:0]  cfg_data,
    // input item
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         mode,
    input  logic [7:0]   frame_type,
    input  logic [7:0]   body_len,
    input  logic [15:0]  origin_addr,
    input  logic [31:0]  event_id,
    input  logic [7:0]   ttl_in,
    input  logic [31:0]  now_halfsec,
    // result item
    output logic         out_valid,
    input  logic         out_stall,
    output logic         forward,
    output logic [2:0]   verdict,
    output logic [7:0]   ttl_out,
    output logic [3:0]   slot_written,
    output logic         evicted,
    output logic [4:0]   aged_out
);

    // commands from the sequencer, status back from the table datapath
    frdf_cmd_t    cmd;
    frdf_status_t status;

    // sequencer: idle, scan every slot, drain the last read, write back
    frdf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // table, checks, oldest-entry search, aging and the result register
    frdf_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mode         (mode),
        .frame_type   (frame_type),
        .body_len     (body_len),
        .origin_addr  (origin_addr),
        .event_id     (event_id),
        .ttl_in       (ttl_in),
        .now_halfsec  (now_halfsec),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .forward      (forward),
        .verdict      (verdict),
        .ttl_out      (ttl_out),
        .slot_written (slot_written),
        .evicted      (evicted),
        .aged_out     (aged_out)
    );

endmodule

@@ dv/flood_relay_dedup_filter_tb.sv @@
`timescale 1ns / 100ps

module flood_relay_dedup_filter_tb
    import frdf_pkg::*;
();

    // table depth under test, kept equal to the block's default
    localparam int SLOTS = 16;

    // number of random phases, each with its own register setting
    localparam int PHASES = 8;
    localparam int ITEMS_PER_PHASE = 212;

    // one received frame or sweep request as it crosses the input channel
    typedef struct {
        bit        mode;
        bit [7:0]  frame_type;
        bit [7:0]  body_len;
        bit [15:0] origin_addr;
        bit [31:0] event_id;
        bit [7:0]  ttl_in;
        bit [31:0] now_halfsec;
    } frame_item_t;

    // one verdict as it leaves the output channel; four-state so that x shows up
    typedef struct {
        logic       forward;
        logic [2:0] verdict;
        logic [7:0] ttl_out;
        logic [3:0] slot_written;
        logic       evicted;
        logic [4:0] aged_out;
    } relay_result_t;

    // receiver behaviour over one stretch of cycles
    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_style_t;

    // -------------------------------------------------------------------------
    // mirror of the duplicate table plus the queue of verdicts still owed
    // -------------------------------------------------------------------------
    class relay_table_scoreboard;
        bit [7:0]      relay_type;
        bit [15:0]     timeout_s;
        bit            slot_valid  [SLOTS];
        bit [15:0]     slot_origin [SLOTS];
        bit [31:0]     slot_event  [SLOTS];
        bit [31:0]     slot_stamp  [SLOTS];
        relay_result_t awaited_verdicts [$];
        int unsigned   errors;

        function new();
            relay_type = 8'h00;
            timeout_s  = TIMEOUT_RESET;
            errors     = 0;
            foreach (slot_valid[i])
                slot_valid[i] = 1'b0;
        endfunction

        function void set_config(bit [7:0] new_type, bit [15:0] new_timeout);
            relay_type = new_type;
            timeout_s  = new_timeout;
        endfunction

        function int unsigned pending();
            return awaited_verdicts.size();
        endfunction

        // works out the verdict for one accepted transfer and updates the table
        function void record_frame(frame_item_t it);
            relay_result_t r;
            bit [31:0]     age_limit;
            bit [31:0]     age;
            bit [31:0]     oldest;
            bit [4:0]      swept;
            bit            seen;
            int            free_slot;
            int            pick;

            r.forward      = 1'b0;
            r.verdict      = VERDICT_FORWARD;
            r.ttl_out      = it.ttl_in;
            r.slot_written = '0;
            r.evicted      = 1'b0;
            r.aged_out     = '0;

            seen = 1'b0;
            for (int i = 0; i < SLOTS; i++)
                if (slot_valid[i] && slot_origin[i] == it.origin_addr
                        && slot_event[i] == it.event_id)
                    seen = 1'b1;

            if (it.mode)
            begin
                // ages wrap, the limit is the timeout in half seconds
                age_limit = {15'b0, timeout_s, 1'b0};
                swept     = '0;
                for (int i = 0; i < SLOTS; i++)
                begin
                    age = it.now_halfsec - slot_stamp[i];
                    if (slot_valid[i] && age > age_limit)
                    begin
                        slot_valid[i] = 1'b0;
                        swept++;
                    end
                end
                r.verdict  = VERDICT_SWEEP_DONE;
                r.aged_out = swept;
            end
            else if (it.frame_type != relay_type)
            begin
                r.verdict = VERDICT_WRONG_TYPE;
            end
            else if (it.body_len < MIN_LEN)
            begin
                r.verdict = VERDICT_TOO_SHORT;
            end
            else if (seen)
            begin
                r.verdict = VERDICT_DUPLICATE;
            end
            else if (it.ttl_in == 8'd0)
            begin
                r.verdict = VERDICT_TTL_ZERO;
            end
            else
            begin
                // lowest free slot, else strictly smallest raw stamp, slot 0 if all ones
                free_slot = -1;
                pick      = 0;
                oldest    = 32'hFFFF_FFFF;
                for (int i = 0; i < SLOTS; i++)
                begin
                    if (!slot_valid[i])
                    begin
                        if (free_slot < 0)
                            free_slot = i;
                    end
                    else if (slot_stamp[i] < oldest)
                    begin
                        oldest = slot_stamp[i];
                        pick   = i;
                    end
                end
                if (free_slot >= 0)
                    pick = free_slot;
                r.forward      = 1'b1;
                r.ttl_out      = it.ttl_in - 8'd1;   // ttl is nonzero here
                r.slot_written = 4'(pick);
                r.evicted      = slot_valid[pick];
                slot_valid[pick]  = 1'b1;
                slot_origin[pick] = it.origin_addr;
                slot_event[pick]  = it.event_id;
                slot_stamp[pick]  = it.now_halfsec;
            end
            awaited_verdicts.push_back(r);
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_result(relay_result_t got);
            relay_result_t want;
            if (awaited_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t ns: result transfer, expected none, actual verdict %0d",
                         $time, got.verdict);
                return;
            end
            want = awaited_verdicts.pop_front();
            compare_field("forward",      want.forward,      got.forward);
            compare_field("verdict",      want.verdict,      got.verdict);
            compare_field("ttl_out",      want.ttl_out,      got.ttl_out);
            compare_field("slot_written", want.slot_written, got.slot_written);
            compare_field("evicted",      want.evicted,      got.evicted);
            compare_field("aged_out",     want.aged_out,     got.aged_out);
        endfunction
    endclass

    // -------------------------------------------------------------------------
    // block wiring
    // -------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic        mode;
    logic [7:0]  frame_type;
    logic [7:0]  body_len;
    logic [15:0] origin_addr;
    logic [31:0] event_id;
    logic [7:0]  ttl_in;
    logic [31:0] now_halfsec;
    logic        out_valid;
    logic        out_stall;
    logic        forward;
    logic [2:0]  verdict;
    logic [7:0]  ttl_out;
    logic [3:0]  slot_written;
    logic        evicted;
    logic [4:0]  aged_out;

    relay_table_scoreboard scoreboard = new();
    relay_result_t         seen_result;

    // transfers left in the current sender burst
    int burst_left = 0;

    flood_relay_dedup_filter #(
        .TABLE_ENTRIES (SLOTS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .frame_type   (frame_type),
        .body_len     (body_len),
        .origin_addr  (origin_addr),
        .event_id     (event_id),
        .ttl_in       (ttl_in),
        .now_halfsec  (now_halfsec),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .forward      (forward),
        .verdict      (verdict),
        .ttl_out      (ttl_out),
        .slot_written (slot_written),
        .evicted      (evicted),
        .aged_out     (aged_out)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // watchdog, well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // -------------------------------------------------------------------------
    // helpers for the sender side
    // -------------------------------------------------------------------------
    function automatic frame_item_t make_frame(bit m, bit [7:0] ftype, bit [7:0] len,
                                               bit [15:0] origin, bit [31:0] evt,
                                               bit [7:0] ttl, bit [31:0] now);
        frame_item_t it;
        it.mode        = m;
        it.frame_type  = ftype;
        it.body_len    = len;
        it.origin_addr = origin;
        it.event_id    = evt;
        it.ttl_in      = ttl;
        it.now_halfsec = now;
        return it;
    endfunction

    // offers one item and holds it until the transfer happens; bursts with random gaps
    task automatic offer_frame(input frame_item_t it);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge clk);
            // now and then a long unbroken burst
            burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
        end
        burst_left--;
        in_valid    <= 1'b1;
        mode        <= it.mode;
        frame_type  <= it.frame_type;
        body_len    <= it.body_len;
        origin_addr <= it.origin_addr;
        event_id    <= it.event_id;
        ttl_in      <= it.ttl_in;
        now_halfsec <= it.now_halfsec;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        scoreboard.record_frame(it);
    endtask

    // stop offering and wait until every owed verdict has come out
    task automatic wait_idle();
        in_valid  <= 1'b0;
        burst_left = 0;
        while (scoreboard.pending() != 0)
            @(posedge clk);
    endtask

    // both registers written back to back; junk in the unused upper byte of the type
    task automatic apply_config(input bit [7:0] new_type, input bit [15:0] new_timeout);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_RELAY_TYPE;
        cfg_data  <= {8'($urandom), new_type};
        @(posedge clk);
        cfg_index <= CFG_TIMEOUT;
        cfg_data  <= new_timeout;
        @(posedge clk);
        cfg_we    <= 1'b0;
        scoreboard.set_config(new_type, new_timeout);
    endtask

    // -------------------------------------------------------------------------
    // receiver: stalls in stretches of its own, with a long hold every so often
    // so that the result register stays full and the input side backs up
    // -------------------------------------------------------------------------
    initial
    begin
        int unsigned  stretch;
        int unsigned  span;
        stall_style_t style;

        out_stall <= 1'b0;
        stretch = 0;
        forever
        begin
            stretch++;
            span  = $urandom_range(4, 60);
            style = stall_style_t'($urandom_range(0, 2));
            if (stretch % 25 == 0)
            begin
                span  = 120;
                style = STALL_HOLD;
            end
            for (int k = 0; k < span; k++)
            begin
                @(posedge clk);
                case (style)
                    STALL_NONE:  out_stall <= 1'b0;
                    STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
                    default:     out_stall <= 1'b1;
                endcase
            end
        end
    end

    // result monitor, sampling the values that stood before the edge
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            seen_result.forward      = forward;
            seen_result.verdict      = verdict;
            seen_result.ttl_out      = ttl_out;
            seen_result.slot_written = slot_written;
            seen_result.evicted      = evicted;
            seen_result.aged_out     = aged_out;
            scoreboard.check_result(seen_result);
        end
    end

    // -------------------------------------------------------------------------
    // main sequence
    // -------------------------------------------------------------------------
    initial
    begin
        frame_item_t it;
        bit [7:0]    relay;
        bit [15:0]   tmo;
        bit [31:0]   now_cursor;
        bit [31:0]   step_max;
        bit [47:0]   recent_ids [$];
        bit [47:0]   id;
        int unsigned pick;

        // every input known from time zero
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_index   <= CFG_RELAY_TYPE;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        mode        <= 1'b0;
        frame_type  <= '0;
        body_len    <= '0;
        origin_addr <= '0;
        event_id    <= '0;
        ttl_in      <= '0;
        now_halfsec <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // --- directed part, at the reset setting: relay type 0, timeout 30 s ---

        // sweep of an empty table
        offer_frame(make_frame(1'b1, 8'hFF, 8'h00, 16'h0000, 32'h0, 8'hFF, 32'h0));
        // rejected frames: wrong type, one byte short, ttl already zero
        offer_frame(make_frame(1'b0, 8'h80, 8'd9, 16'h0001, 32'h1, 8'd5, 32'd100));
        offer_frame(make_frame(1'b0, 8'h00, 8'd8, 16'h0001, 32'h1, 8'd5, 32'd100));
        offer_frame(make_frame(1'b0, 8'h00, 8'd9, 16'h0000, 32'h0, 8'd0, 32'd100));
        // fill every slot, all stamped all ones; the first one has ttl 1 and goes to 0
        for (int i = 0; i < SLOTS; i++)
            offer_frame(make_frame(1'b0, 8'h00,
                                   (i == 0) ? 8'hFF : 8'(9 + i),
                                   (i == 0) ? 16'hFFFF : 16'(i),
                                   (i == 0) ? 32'hFFFF_FFFF : (32'h8000_0000 | 32'(i)),
                                   (i == 0) ? 8'd1 : 8'(i * 17),
                                   32'hFFFF_FFFF));
        // duplicate wins over a zero ttl
        offer_frame(make_frame(1'b0, 8'h00, 8'd9, 16'hFFFF, 32'hFFFF_FFFF, 8'd0, 32'd5));
        // full table, all stamps all ones: slot 0 is replaced
        offer_frame(make_frame(1'b0, 8'h00, 8'd9, 16'hFFFF, 32'h0, 8'hFF, 32'h10));
        // raw stamp order, not wrapping age: slot 0 again
        offer_frame(make_frame(1'b0, 8'h00, 8'd9, 16'h0007, 32'h7, 8'd2, 32'h20));
        // sweeps: fifteen slots one past the limit, then exactly at it, then one past
        offer_frame(make_frame(1'b1, 8'h00, 8'd0, 16'h0, 32'h0, 8'd3, 32'h3C));
        offer_frame(make_frame(1'b1, 8'h00, 8'd0, 16'h0, 32'h0, 8'd0, 32'h5C));
        offer_frame(make_frame(1'b1, 8'h00, 8'd0, 16'h0, 32'h0, 8'd9, 32'h5D));

        // --- random phases, each under its own setting ---
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                relay = 8'hFF;
                tmo   = 16'h0000;
            end
            else if (phase == 1)
            begin
                relay = 8'h00;
                tmo   = 16'hFFFF;
            end
            else if (phase == 2)
            begin
                relay = 8'($urandom);
                tmo   = 16'd1;
            end
            else if (phase == 3)
            begin
                relay = 8'($urandom);
                tmo   = 16'($urandom_range(2, 40));
            end
            else
            begin
                relay = 8'($urandom);
                tmo   = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(5, 300));
            end
            wait_idle();
            apply_config(relay, tmo);

            // odd phases start close to the wrap of the half-second counter
            now_cursor = (phase % 2 == 1) ? 32'hFFFF_FFFF - $urandom_range(0, 4000)
                                          : $urandom;
            // time moves so that entries age out over a phase, with frequent equal stamps
            step_max = (32'(tmo) >> 1) + 1;
            recent_ids.delete();

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                pick = $urandom_range(0, 99);
                now_cursor += $urandom_range(0, step_max);
                it = make_frame(1'b0, relay, 8'($urandom_range(9, 255)), 16'($urandom),
                                $urandom, 8'($urandom_range(1, 255)), now_cursor);
                if (pick < 8)
                begin
                    // sweep, the other fields are don't-care noise
                    it.mode       = 1'b1;
                    it.frame_type = 8'($urandom);
                    it.body_len   = 8'($urandom);
                    it.ttl_in     = 8'($urandom);
                end
                else if (pick < 13)
                begin
                    it.frame_type = 8'($urandom);
                end
                else if (pick < 18)
                begin
                    it.body_len = 8'($urandom_range(0, 8));
                end
                else if (pick < 22)
                begin
                    it.ttl_in = 8'd0;
                end
                // replay a recent origin and event so duplicates are common
                if (pick >= 13 && recent_ids.size() > 0 && $urandom_range(0, 99) < 40)
                begin
                    id = recent_ids[$urandom_range(0, recent_ids.size() - 1)];
                    it.origin_addr = id[47:32];
                    it.event_id    = id[31:0];
                    // near miss: same origin, event off by one bit
                    if ($urandom_range(0, 9) == 0)
                        it.event_id[$urandom_range(0, 31)] ^= 1'b1;
                end
                else if (pick >= 22)
                begin
                    recent_ids.push_back({it.origin_addr, it.event_id});
                    if (recent_ids.size() > 24)
                        void'(recent_ids.pop_front());
                end
                // stray timestamp now and then
                if ($urandom_range(0, 29) == 0)
                    it.now_halfsec = $urandom;
                offer_frame(it);
            end
        end

        // drain, then leave room for any stray extra transfer
        wait_idle();
        repeat (60) @(posedge clk);
        if (scoreboard.errors == 0 && scoreboard.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/frdf_pkg.sv
hw/rtl/frdf_ram.sv
hw/rtl/frdf_ctrl.sv
hw/rtl/frdf_datapath.sv
hw/rtl/flood_relay_dedup_filter.sv
dv/flood_relay_dedup_filter_tb.sv
